// File: hw/rtl/convex_polygon_sat_collision_macros.svh
// Assertion helpers used by the top-level RTL file.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef CONVEX_POLYGON_SAT_COLLISION_MACROS_SVH
`define CONVEX_POLYGON_SAT_COLLISION_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CPSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CPSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/cpsc_pkg.sv
`timescale 1ns / 1ps

package cpsc_pkg;

  // Default polygon capacity
  localparam int MAX_VERTS_DEF = 16;
  // Fewest vertices that make a polygon
  localparam int MIN_VERTS = 3;
  // Packed vertex: {x, y}, each Q16.16
  localparam int COORD_W = 32;
  localparam int VERT_W = 2 * COORD_W;

  // Item kinds
  typedef enum logic [1:0] {
    K_FIRST_VERT    = 2'd0,
    K_SECOND_VERT   = 2'd1,
    K_FIRST_ORIGIN  = 2'd2,
    K_SECOND_ORIGIN = 2'd3
  } kind_t;

  // Test sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_A,
    ST_EDGE_B,
    ST_EDGE_C,
    ST_AXIS,
    ST_OFF_MUL,
    ST_OFF_SUM,
    ST_PROJ,
    ST_SHIFT,
    ST_CMP,
    ST_UPD,
    ST_SCALE_MUL,
    ST_SCALE_OUT
  } seq_state_t;

  // Unit axis unit states
  typedef enum logic [2:0] {
    AX_IDLE,
    AX_NORM,
    AX_SQ_A,
    AX_SQ_B,
    AX_ROOT,
    AX_DIV,
    AX_DONE
  } ax_state_t;

  // Unit axis, Q2.30
  typedef struct packed {
    logic        done;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
  } axis_res_t;

endpackage

// File: hw/rtl/cpsc_ram.sv
`timescale 1ns / 1ps

module cpsc_ram #(
  parameter int WIDTH = cpsc_pkg::VERT_W,
  parameter int DEPTH = cpsc_pkg::MAX_VERTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/cpsc_axis.sv
`timescale 1ns / 1ps

// Turns an edge normal into a unit axis in Q2.30: normalise, sum of squares,
// bit-serial square root, then two restoring dividers side by side.
module cpsc_axis (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [32:0]     nx,
  input  logic signed [32:0]     ny,
  output cpsc_pkg::axis_res_t    res
);

  localparam int ROOT_STEPS = 32;
  localparam int QUO_W = 31;

  cpsc_pkg::ax_state_t state, state_next;

  logic        neg_x, neg_y;
  logic [32:0] a, b;
  logic [62:0] s;
  logic [63:0] r;
  logic [63:0] bitm;
  logic [4:0]  cnt;
  logic [32:0] rem_a, rem_b;
  logic [QUO_W-1:0] q_a, q_b;

  logic [32:0] m;
  logic [30:0] mul_op;
  logic [61:0] sq;
  logic [63:0] trial;
  logic        ge_r;
  logic [31:0] len;
  logic        in_a;
  logic [32:0] sh_a, sh_b;
  logic        ge_a, ge_b;
  logic signed [31:0] qa_s, qb_s;

  // Shared arithmetic
  assign m      = (a > b) ? a : b;
  assign mul_op = (state == cpsc_pkg::AX_SQ_A) ? a[30:0] : b[30:0];
  assign sq     = mul_op * mul_op;
  assign trial  = r + bitm;
  assign ge_r   = {1'b0, s} >= trial;
  assign len    = r[31:0];
  assign in_a   = (cnt == 5'(QUO_W - 1)) ? a[0] : 1'b0;
  assign sh_a   = {rem_a[31:0], in_a};
  assign sh_b   = {rem_b[31:0], ((cnt == 5'(QUO_W - 1)) ? b[0] : 1'b0)};
  assign ge_a   = sh_a >= {1'b0, len};
  assign ge_b   = sh_b >= {1'b0, len};
  assign qa_s   = {1'b0, q_a};
  assign qb_s   = {1'b0, q_b};

  // Result
  assign res.done = (state == cpsc_pkg::AX_DONE);
  assign res.ax   = neg_x ? -qa_s : qa_s;
  assign res.ay   = neg_y ? -qb_s : qb_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpsc_pkg::AX_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      cpsc_pkg::AX_IDLE: if (start) state_next = cpsc_pkg::AX_NORM;
      cpsc_pkg::AX_NORM: begin
        if (m == '0) begin
          state_next = cpsc_pkg::AX_DONE;
        end else if (m[32:31] == 2'b00 && m[30]) begin
          state_next = cpsc_pkg::AX_SQ_A;
        end
      end
      cpsc_pkg::AX_SQ_A: state_next = cpsc_pkg::AX_SQ_B;
      cpsc_pkg::AX_SQ_B: state_next = cpsc_pkg::AX_ROOT;
      cpsc_pkg::AX_ROOT: if (cnt == '0) state_next = cpsc_pkg::AX_DIV;
      cpsc_pkg::AX_DIV:  if (cnt == '0) state_next = cpsc_pkg::AX_DONE;
      cpsc_pkg::AX_DONE: state_next = cpsc_pkg::AX_IDLE;
      default:           state_next = cpsc_pkg::AX_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      cpsc_pkg::AX_IDLE: begin
        if (start) begin
          a     <= nx[32] ? 33'(-nx) : 33'(nx);
          b     <= ny[32] ? 33'(-ny) : 33'(ny);
          neg_x <= nx[32];
          neg_y <= ny[32];
        end
      end
      cpsc_pkg::AX_NORM: begin
        // one bit of shift a cycle until the larger magnitude is in [2^30, 2^31)
        if (m == '0) begin
          q_a <= '0;
          q_b <= '0;
        end else if (m[32:31] != 2'b00) begin
          a <= a >> 1;
          b <= b >> 1;
        end else if (!m[30]) begin
          a <= a << 1;
          b <= b << 1;
        end
      end
      cpsc_pkg::AX_SQ_A: s <= {1'b0, sq};
      cpsc_pkg::AX_SQ_B: begin
        s    <= s + {1'b0, sq};
        r    <= '0;
        bitm <= 64'd1 << 62;
        cnt  <= 5'(ROOT_STEPS - 1);
      end
      cpsc_pkg::AX_ROOT: begin
        if (ge_r) begin
          s <= s - trial[62:0];
          r <= (r >> 1) + bitm;
        end else begin
          r <= r >> 1;
        end
        bitm <= bitm >> 2;
        if (cnt == '0) begin
          rem_a <= {3'b000, a[30:1]};
          rem_b <= {3'b000, b[30:1]};
          cnt   <= 5'(QUO_W - 1);
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
      cpsc_pkg::AX_DIV: begin
        rem_a <= ge_a ? (sh_a - {1'b0, len}) : sh_a;
        rem_b <= ge_b ? (sh_b - {1'b0, len}) : sh_b;
        q_a   <= {q_a[QUO_W-2:0], ge_a};
        q_b   <= {q_b[QUO_W-2:0], ge_b};
        cnt   <= cnt - 5'd1;
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/convex_polygon_sat_collision.sv
// Separating-axis collision test for two convex polygons.
// Input channel: an item transfers at a clock edge with start high and busy
// low. kind 0 and 1 append a vertex (x_coord, y_coord, Q16.16) to the first
// or second polygon, kind 2 loads the first origin, kind 3 carries the second
// origin and starts the test. Loads never raise busy.
// Result channel: done is high for exactly one cycle with hit, overlap_x and
// overlap_y; the receiver cannot hold it off and takes it at that edge.
// A test with fewer than three vertices in either polygon answers in the
// cycle after the start item. Otherwise each axis goes through the unit axis
// stage, where up to 30 normalising shifts precede the bit-serial square root
// and dividers, and then through the projection of both polygons.
// Projection streams both vertex memories in parallel, one vertex a cycle.
// Vertex counts return to zero after every test; the first origin is kept.
// Reset clears the counts, the first origin and the sequencer; the vertex
// memories are not cleared, and data read beyond the counts is discarded.
`timescale 1ns / 1ps
`include "convex_polygon_sat_collision_macros.svh"

module convex_polygon_sat_collision #(
  parameter int MAX_VERTS = cpsc_pkg::MAX_VERTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  output logic               done,
  output logic               hit,
  output logic signed [31:0] overlap_x,
  output logic signed [31:0] overlap_y
);

  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam int IW = $clog2(MAX_VERTS);

  cpsc_pkg::seq_state_t state, state_next;

  // Load state
  logic [CW-1:0]      first_count, second_count;
  logic signed [31:0] origin_x, origin_y;
  logic signed [32:0] dx, dy;

  // Edge walk
  logic               poly_sel;
  logic [IW-1:0]      edge_idx;
  logic [CW-1:0]      n_cur;
  logic signed [31:0] vi_x, vi_y;
  logic signed [31:0] ax, ay;

  // Offset
  logic signed [63:0] pdx, pdy;
  logic signed [33:0] off;
  logic               orient_pos;

  // Projection pipeline
  logic [CW-1:0]      p_idx;
  logic [1:0]         s1_v, s2_v;
  logic               s1_f, s2_f;
  logic signed [63:0] p1x, p1y, p2x, p2y;
  logic signed [33:0] lo1, hi1, lo2, hi2;
  logic signed [34:0] lo2s, hi2s;
  logic               sep;
  logic [34:0]        ovl;

  // Best axis
  logic               best_valid;
  logic [34:0]        best_dist;
  logic signed [31:0] best_ax, best_ay;
  logic               best_pos;
  logic [65:0]        sx, sy;

  // Memory ports
  logic                we1, we2;
  logic [IW-1:0]       raddr;
  logic [cpsc_pkg::VERT_W-1:0] wdata, rd1, rd2, rd_sel;

  // Control
  logic                acc, enough, ax_start, fin, fin_hit;
  logic [CW-1:0]       edge_inc, n_max;
  logic                last_edge, issue, pipe_busy;
  logic [IW-1:0]       j_idx;
  cpsc_pkg::axis_res_t ax_res;

  // Combinational arithmetic
  logic signed [31:0] rsx, rsy, r1x, r1y, r2x, r2y;
  logic signed [32:0] nx_w, ny_w;
  logic signed [64:0] mdx, mdy;
  logic signed [63:0] m1x, m1y, m2x, m2y, sum1, sum2, exact;
  logic signed [33:0] d1, d2;
  logic signed [34:0] lo2_w, hi2_w, hi_min, lo_max;
  logic signed [35:0] dist_w;
  logic [30:0]        mag_ax, mag_ay;
  logic [31:0]        out_x, out_y;

  function automatic logic [31:0] scale_sat(input logic [35:0] v, input logic neg);
    logic [31:0] res;
    if (neg) begin
      res = (v > 36'h080000000) ? 32'h80000000 : (~v[31:0] + 32'd1);
    end else begin
      res = (v > 36'h07FFFFFFF) ? 32'h7FFFFFFF : v[31:0];
    end
    return res;
  endfunction

  assign busy   = (state != cpsc_pkg::ST_IDLE);
  assign acc    = start && !busy;
  assign enough = (first_count >= CW'(cpsc_pkg::MIN_VERTS)) &&
                  (second_count >= CW'(cpsc_pkg::MIN_VERTS));

  // Vertex memories
  assign wdata = {x_coord, y_coord};
  assign we1 = acc && (kind == cpsc_pkg::K_FIRST_VERT) && (first_count < CW'(MAX_VERTS));
  assign we2 = acc && (kind == cpsc_pkg::K_SECOND_VERT) && (second_count < CW'(MAX_VERTS));

  assign edge_inc  = CW'(edge_idx) + CW'(1);
  assign last_edge = (edge_inc == n_cur);
  assign j_idx     = last_edge ? '0 : edge_inc[IW-1:0];
  assign raddr = (state == cpsc_pkg::ST_PROJ)   ? p_idx[IW-1:0] :
                 (state == cpsc_pkg::ST_EDGE_B) ? j_idx : edge_idx;

  cpsc_ram #(.WIDTH(cpsc_pkg::VERT_W), .DEPTH(MAX_VERTS)) u_first_mem (
    .clk(clk), .we(we1), .waddr(first_count[IW-1:0]), .wdata(wdata),
    .raddr(raddr), .rdata(rd1)
  );

  cpsc_ram #(.WIDTH(cpsc_pkg::VERT_W), .DEPTH(MAX_VERTS)) u_second_mem (
    .clk(clk), .we(we2), .waddr(second_count[IW-1:0]), .wdata(wdata),
    .raddr(raddr), .rdata(rd2)
  );

  // Edge normal (e.y, -e.x) into the unit axis stage
  assign rd_sel = poly_sel ? rd2 : rd1;
  assign rsx  = rd_sel[63:32];
  assign rsy  = rd_sel[31:0];
  assign nx_w = rsy - vi_y;
  assign ny_w = vi_x - rsx;

  cpsc_axis u_axis (
    .clk(clk), .rst(rst), .start(ax_start), .nx(nx_w), .ny(ny_w), .res(ax_res)
  );

  // Offset and projection products
  assign mdx   = dx * ax;
  assign mdy   = dy * ay;
  assign exact = pdx + pdy;
  assign r1x = rd1[63:32];
  assign r1y = rd1[31:0];
  assign r2x = rd2[63:32];
  assign r2y = rd2[31:0];
  assign m1x = r1x * ax;
  assign m1y = r1y * ay;
  assign m2x = r2x * ax;
  assign m2y = r2y * ay;
  assign sum1 = p1x + p1y;
  assign sum2 = p2x + p2y;
  // floor of a division by 2^30
  assign d1 = sum1[63:30];
  assign d2 = sum2[63:30];

  assign n_max     = (first_count > second_count) ? first_count : second_count;
  assign issue     = (state == cpsc_pkg::ST_PROJ) && (p_idx < n_max);
  assign pipe_busy = (s1_v != 2'b00) || (s2_v != 2'b00);

  // Overlap on the current axis
  assign lo2_w  = lo2 + off;
  assign hi2_w  = hi2 + off;
  assign hi_min = (hi1 < hi2s) ? 35'(hi1) : hi2s;
  assign lo_max = (lo1 > lo2s) ? 35'(lo1) : lo2s;
  assign dist_w = hi_min - lo_max;

  // Result scaling
  assign mag_ax = best_ax[31] ? 31'(-best_ax) : best_ax[30:0];
  assign mag_ay = best_ay[31] ? 31'(-best_ay) : best_ay[30:0];
  assign out_x  = scale_sat(sx[65:30], best_ax[31] ^ !best_pos);
  assign out_y  = scale_sat(sy[65:30], best_ay[31] ^ !best_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    ax_start   = 1'b0;
    fin        = 1'b0;
    fin_hit    = 1'b0;
    case (state)
      cpsc_pkg::ST_IDLE: begin
        if (acc && kind == cpsc_pkg::K_SECOND_ORIGIN) begin
          if (enough) begin
            state_next = cpsc_pkg::ST_EDGE_A;
          end else begin
            fin = 1'b1;
          end
        end
      end
      cpsc_pkg::ST_EDGE_A: state_next = cpsc_pkg::ST_EDGE_B;
      cpsc_pkg::ST_EDGE_B: state_next = cpsc_pkg::ST_EDGE_C;
      cpsc_pkg::ST_EDGE_C: begin
        ax_start   = 1'b1;
        state_next = cpsc_pkg::ST_AXIS;
      end
      cpsc_pkg::ST_AXIS:    if (ax_res.done) state_next = cpsc_pkg::ST_OFF_MUL;
      cpsc_pkg::ST_OFF_MUL: state_next = cpsc_pkg::ST_OFF_SUM;
      cpsc_pkg::ST_OFF_SUM: state_next = cpsc_pkg::ST_PROJ;
      cpsc_pkg::ST_PROJ:    if (!issue && !pipe_busy) state_next = cpsc_pkg::ST_SHIFT;
      cpsc_pkg::ST_SHIFT:   state_next = cpsc_pkg::ST_CMP;
      cpsc_pkg::ST_CMP:     state_next = cpsc_pkg::ST_UPD;
      cpsc_pkg::ST_UPD: begin
        if (sep) begin
          fin        = 1'b1;
          state_next = cpsc_pkg::ST_IDLE;
        end else if (last_edge && poly_sel) begin
          state_next = cpsc_pkg::ST_SCALE_MUL;
        end else begin
          state_next = cpsc_pkg::ST_EDGE_A;
        end
      end
      cpsc_pkg::ST_SCALE_MUL: state_next = cpsc_pkg::ST_SCALE_OUT;
      cpsc_pkg::ST_SCALE_OUT: begin
        fin        = 1'b1;
        fin_hit    = 1'b1;
        state_next = cpsc_pkg::ST_IDLE;
      end
      default: state_next = cpsc_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
      origin_x     <= '0;
      origin_y     <= '0;
      done         <= 1'b0;
      s1_v         <= 2'b00;
      s2_v         <= 2'b00;
    end else begin
      if (we1) first_count <= first_count + CW'(1);
      if (we2) second_count <= second_count + CW'(1);
      if (acc && kind == cpsc_pkg::K_FIRST_ORIGIN) begin
        origin_x <= x_coord;
        origin_y <= y_coord;
      end
      if (fin) begin
        first_count  <= '0;
        second_count <= '0;
      end
      done <= fin;
      s1_v <= {issue && (p_idx < second_count), issue && (p_idx < first_count)};
      s2_v <= s1_v;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (fin) begin
      hit       <= fin_hit;
      overlap_x <= fin_hit ? out_x : '0;
      overlap_y <= fin_hit ? out_y : '0;
    end

    s1_f <= (p_idx == '0);
    s2_f <= s1_f;
    p1x  <= m1x;
    p1y  <= m1y;
    p2x  <= m2x;
    p2y  <= m2y;

    // min/max of each projection, first vertex seeds the range
    if (s2_v[0]) begin
      if (s2_f) begin
        lo1 <= d1;
        hi1 <= d1;
      end else begin
        if (d1 < lo1) lo1 <= d1;
        if (d1 > hi1) hi1 <= d1;
      end
    end
    if (s2_v[1]) begin
      if (s2_f) begin
        lo2 <= d2;
        hi2 <= d2;
      end else begin
        if (d2 < lo2) lo2 <= d2;
        if (d2 > hi2) hi2 <= d2;
      end
    end

    case (state)
      cpsc_pkg::ST_IDLE: begin
        if (acc && kind == cpsc_pkg::K_SECOND_ORIGIN) begin
          dx         <= x_coord - origin_x;
          dy         <= y_coord - origin_y;
          best_valid <= 1'b0;
          poly_sel   <= 1'b0;
          edge_idx   <= '0;
          n_cur      <= first_count;
        end
      end
      cpsc_pkg::ST_EDGE_B: begin
        vi_x <= rsx;
        vi_y <= rsy;
      end
      cpsc_pkg::ST_AXIS: begin
        if (ax_res.done) begin
          ax <= ax_res.ax;
          ay <= ax_res.ay;
        end
      end
      cpsc_pkg::ST_OFF_MUL: begin
        pdx <= mdx[63:0];
        pdy <= mdy[63:0];
      end
      cpsc_pkg::ST_OFF_SUM: begin
        off        <= exact[63:30];
        orient_pos <= (exact > 64'sd0);
        p_idx      <= '0;
      end
      cpsc_pkg::ST_PROJ: if (issue) p_idx <= p_idx + CW'(1);
      cpsc_pkg::ST_SHIFT: begin
        lo2s <= lo2_w;
        hi2s <= hi2_w;
      end
      cpsc_pkg::ST_CMP: begin
        sep <= (lo1 > hi2s) || (hi1 < lo2s);
        ovl <= dist_w[34:0];
      end
      cpsc_pkg::ST_UPD: begin
        // earliest axis wins on equal overlap
        if (!sep && (!best_valid || ovl < best_dist)) begin
          best_valid <= 1'b1;
          best_dist  <= ovl;
          best_ax    <= ax;
          best_ay    <= ay;
          best_pos   <= orient_pos;
        end
        if (!last_edge) begin
          edge_idx <= edge_inc[IW-1:0];
        end else if (!poly_sel) begin
          poly_sel <= 1'b1;
          edge_idx <= '0;
          n_cur    <= second_count;
        end
      end
      cpsc_pkg::ST_SCALE_MUL: begin
        sx <= mag_ax * best_dist;
        sy <= mag_ay * best_dist;
      end
      default: ;
    endcase
  end

  // Checks
  `CPSC_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while a test is running")
  `CPSC_ASSERT_IMP(a_miss_zero, done && !hit, overlap_x == 0 && overlap_y == 0,
                   "miss reported with a non-zero vector")
  `CPSC_ASSERT_NXT(a_short_miss, acc && kind == cpsc_pkg::K_SECOND_ORIGIN && !enough,
                   done && !hit, "short polygon did not give an immediate miss")
  `CPSC_ASSERT_NXT(a_origin_hold, busy, $stable(origin_x) && $stable(origin_y),
                   "first origin changed during a test")
  `CPSC_ASSERT_IMP(a_count_max, 1'b1,
                   first_count <= CW'(MAX_VERTS) && second_count <= CW'(MAX_VERTS),
                   "vertex count beyond capacity")

endmodule
